// ----- src/rc4_stream_cipher_unit_defines.svh -----
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rc4_pkg.sv -----
package rc4_pkg;

    localparam int unsigned MAX_KEY_BYTES = 256;
    localparam int unsigned PERM_DEPTH    = 256;
    localparam int unsigned KEY_DEPTH     = 256;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_count;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD_A = 6'b000010,
        ST_RD_B = 6'b000100,
        ST_WR_A = 6'b001000,
        ST_WR_B = 6'b010000,
        ST_HOLD = 6'b100000
    } t_state;

endpackage

// ----- src/rc4_stream_cipher_unit.sv -----
// RC4 stream cipher unit.
// Input channel (i_in_valid / o_in_ready): i_command selects a key byte or a
// data byte. Key bytes are stored in order (up to 256); the key byte with
// i_key_last set starts the key schedule. A data byte with i_restart set
// clears both keystream pointers before its step.
// Output channel (o_out_valid / i_out_ready): one o_out_byte per data item,
// none per key item.
// A data item passes ST_RD_B, ST_WR_A and ST_WR_B on its way to the output
// register; the permutation memory has one read and one write port, and one
// swap needs three reads and two writes. A new item is taken only in ST_IDLE.
// A key byte without i_key_last leaves the unit in ST_IDLE. The key schedule
// runs 256 swap steps through ST_RD_A to ST_WR_B, with o_in_ready low.
// A stalled output holds its byte while the next item is already taken in;
// a finished data step whose output register is still full waits for it.
// Reset (synchronous, active low) restores the identity permutation at once
// through per-entry valid flags, and clears the pointers and key count.
module rc4_stream_cipher_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_command,
    input  logic [7:0] i_byte_in,
    input  logic i_key_last,
    input  logic i_restart,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic [7:0] o_out_byte
);

`include "rc4_stream_cipher_unit_defines.svh"

    rc4_pkg::t_state r_state, n_state;

    rc4_pkg::t_byte  r_s_mem [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::PERM_DEPTH-1:0] r_s_vld;
    rc4_pkg::t_byte  r_s_q;
    logic            r_rd_vld;
    rc4_pkg::t_byte  r_rd_addr;

    rc4_pkg::t_byte  r_k_mem [rc4_pkg::KEY_DEPTH];
    rc4_pkg::t_byte  r_k_q;

    rc4_pkg::t_count r_key_count;
    rc4_pkg::t_byte  r_kidx;
    rc4_pkg::t_byte  r_i;
    rc4_pkg::t_byte  r_j;
    logic            r_ks;

    rc4_pkg::t_byte  r_si;
    rc4_pkg::t_byte  r_sj;
    rc4_pkg::t_byte  r_t;
    rc4_pkg::t_byte  r_data;
    rc4_pkg::t_byte  r_res;

    logic            r_out_vld;
    rc4_pkg::t_byte  r_out_byte;

    logic            in_acc;
    logic            key_acc;
    logic            data_acc;
    logic            key_room;
    logic            sched_start;
    logic            out_free;
    rc4_pkg::t_byte  rd_val;
    rc4_pkg::t_byte  kb;
    rc4_pkg::t_byte  i_start;
    rc4_pkg::t_byte  j_start;
    rc4_pkg::t_byte  ra;
    logic            we;
    rc4_pkg::t_byte  wa;
    rc4_pkg::t_byte  wd;
    rc4_pkg::t_byte  ks_byte;
    rc4_pkg::t_byte  n_kidx;

    assign o_in_ready  = (r_state == rc4_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign key_acc     = in_acc && (i_command == rc4_pkg::CMD_KEY);
    assign data_acc    = in_acc && (i_command == rc4_pkg::CMD_DATA);
    assign key_room    = (r_key_count < rc4_pkg::t_count'(rc4_pkg::MAX_KEY_BYTES));
    assign sched_start = key_acc && i_key_last;
    assign out_free    = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;

    assign rd_val  = r_rd_vld ? r_s_q : r_rd_addr;
    assign kb      = (r_key_count == '0) ? 8'h00 : r_k_q;
    assign i_start = (i_restart ? 8'h00 : r_i) + 8'h01;
    assign j_start = i_restart ? 8'h00 : r_j;
    assign n_kidx  = (({1'b0, r_kidx} + 9'd1) == r_key_count) ? 8'h00 : r_kidx + 8'h01;

    // keystream byte: later writes to the same entry win, then the memory
    assign ks_byte = (r_t == r_j) ? r_si : ((r_t == r_i) ? r_sj : rd_val);

    always_comb begin
        ra = r_i;
        we = 1'b0;
        wa = r_i;
        wd = rd_val;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                ra = i_start;
            end
            rc4_pkg::ST_RD_A: begin
                ra = r_i;
            end
            rc4_pkg::ST_RD_B: begin
                ra = r_j + rd_val + (r_ks ? kb : 8'h00);
            end
            rc4_pkg::ST_WR_A: begin
                ra = r_si + rd_val;
                we = 1'b1;
                wa = r_i;
                wd = rd_val;
            end
            rc4_pkg::ST_WR_B: begin
                we = 1'b1;
                wa = r_j;
                wd = r_si;
            end
            default: begin
                ra = r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_s_mem[wa] <= wd;
        end
        r_s_q     <= r_s_mem[ra];
        r_rd_addr <= ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_s_vld[ra];
            if (sched_start) begin
                r_s_vld <= '0;
            end else if (we) begin
                r_s_vld[wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_acc && key_room) begin
            r_k_mem[r_key_count[7:0]] <= i_byte_in;
        end
        r_k_q <= r_k_mem[r_kidx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (sched_start) begin
                    n_state = rc4_pkg::ST_RD_A;
                end else if (data_acc) begin
                    n_state = rc4_pkg::ST_RD_B;
                end
            end
            rc4_pkg::ST_RD_A: n_state = rc4_pkg::ST_RD_B;
            rc4_pkg::ST_RD_B: n_state = rc4_pkg::ST_WR_A;
            rc4_pkg::ST_WR_A: n_state = rc4_pkg::ST_WR_B;
            rc4_pkg::ST_WR_B: begin
                if (r_ks) begin
                    n_state = (r_i == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_RD_A;
                end else begin
                    n_state = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
                end
            end
            rc4_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4_pkg::ST_IDLE;
            r_key_count <= '0;
            r_kidx      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ks        <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                rc4_pkg::ST_IDLE: begin
                    if (key_acc && key_room) begin
                        r_key_count <= r_key_count + 9'd1;
                    end
                    if (sched_start) begin
                        r_ks   <= 1'b1;
                        r_kidx <= '0;
                        r_i    <= '0;
                        r_j    <= '0;
                    end else if (data_acc) begin
                        r_ks <= 1'b0;
                        r_i  <= i_start;
                        r_j  <= j_start;
                    end
                end
                rc4_pkg::ST_RD_B: begin
                    r_j <= r_j + rd_val + (r_ks ? kb : 8'h00);
                end
                rc4_pkg::ST_WR_B: begin
                    if (r_ks) begin
                        r_kidx <= n_kidx;
                        if (r_i == 8'hFF) begin
                            r_ks        <= 1'b0;
                            r_key_count <= '0;
                            r_i         <= '0;
                            r_j         <= '0;
                        end else begin
                            r_i <= r_i + 8'h01;
                        end
                    end else if (out_free) begin
                        r_out_vld <= 1'b1;
                    end
                end
                rc4_pkg::ST_HOLD: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_data <= i_byte_in;
        end
        case (r_state)
            rc4_pkg::ST_RD_B: begin
                r_si <= rd_val;
            end
            rc4_pkg::ST_WR_A: begin
                r_sj <= rd_val;
                r_t  <= r_si + rd_val;
            end
            rc4_pkg::ST_WR_B: begin
                r_res <= r_data ^ ks_byte;
                if (!r_ks && out_free) begin
                    r_out_byte <= r_data ^ ks_byte;
                end
            end
            rc4_pkg::ST_HOLD: begin
                if (out_free) begin
                    r_out_byte <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    `RC4_ASSERT_NOW(a_key_count_max, 1'b1,
        r_key_count <= rc4_pkg::t_count'(rc4_pkg::MAX_KEY_BYTES), "key count above limit")
    `RC4_ASSERT_NEXT(a_data_start, data_acc, (r_state == rc4_pkg::ST_RD_B) && !r_ks,
        "data item did not start its swap")
    `RC4_ASSERT_NEXT(a_sched_end, (r_state == rc4_pkg::ST_WR_B) && r_ks && (r_i == 8'hFF),
        (r_state == rc4_pkg::ST_IDLE) && (r_key_count == '0) && (r_i == '0) && (r_j == '0),
        "key schedule end state wrong")
    `RC4_ASSERT_NEXT(a_stall_hold,
        (r_state == rc4_pkg::ST_WR_B) && !r_ks && r_out_vld && !i_out_ready,
        (r_state == rc4_pkg::ST_HOLD) && r_out_vld, "finished byte lost on stalled output")

endmodule
